>>> rtl/core/nsa_pkg.sv
// Shared types and codes for the note stack with arpeggio step.
// Used by the cell row, the top level and the checker; no dependencies.
package nsa_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int NOTE_W    = 7;
	localparam int SLOT_W    = 5;
	localparam int CNT_W     = 6;
	localparam int STATUS_W  = 2;
	localparam int OP_W      = 3;
	localparam int CAP_W     = 6;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef enum logic [OP_W-1:0] {
		OP_ADD        = 3'd0,
		OP_ADD_ABSENT = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_CONTAINS   = 3'd3,
		OP_STEP       = 3'd4,
		OP_READ       = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_DONE  = 2'd0,
		STS_MISS  = 2'd1,
		STS_FULL  = 2'd2,
		STS_EMPTY = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_ORDERED  = 1'b0,
		REG_CAPACITY = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_INS  = 2'd1,
		ACT_REM  = 2'd2,
		ACT_CLR  = 2'd3
	} act_t;

	// one slot as handed between neighbors
	typedef struct packed {
		logic              valid;
		logic [NOTE_W-1:0] note;
	} slot_t;

	// compare request broadcast to the row when a word is accepted
	typedef struct packed {
		logic              capture;
		logic              ordered;
		logic [NOTE_W-1:0] key;
	} cell_probe_t;

	// update broadcast to the row when a word commits
	typedef struct packed {
		act_t              act;
		logic [NOTE_W-1:0] key;
	} cell_cmd_t;

	// per-cell compare results, held between capture and commit
	typedef struct packed {
		logic match;
		logic ins;
		logic rd;
	} cell_flags_t;

endpackage

>>> rtl/core/note_stack_with_arpeggio_step.sv
// Note stack with arpeggio step: a row of slot cells with parallel compare.
// Words are taken only in idle; commit waits while a result is unread.
// Accept captures every cell's compare against the key, commit picks the
// first hit and shifts the row; the result register frees the input side
// while a result waits. Reset (arst_n, async) empties all slots at once and
// clears count, step position and configuration; no clearing pass follows.
module note_stack_with_arpeggio_step #(
	parameter int DEPTH = nsa_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // note[6:0], slot_index[11:7], zero pad
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status[1:0], note_out[8:2], found_slot[13:9],
	                               // note_count[19:14], zero pad
	output logic [0:0]  m_tuser,   // note_valid[0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import nsa_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (AW > SLOT_W) ? AW : SLOT_W;
	localparam logic [CW-1:0] CAP_INIT =
		CW'((int'(CAP_RESET) > DEPTH) ? DEPTH : int'(CAP_RESET));

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t            state_q;
	logic              ordered_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     cap_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     step_q;

	op_t               op_s1;
	logic [NOTE_W-1:0] key_s1;
	logic [AW-1:0]     step_new_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [NOTE_W-1:0] nout_q;
	logic              nvalid_q;
	logic [SLOT_W-1:0] fslot_q;
	logic [CNT_W-1:0]  count_q;

	logic              accept;
	logic              exec_fire;
	op_t               op_in;
	logic [AW-1:0]     step_new;
	logic [RW-1:0]     rd_addr;
	logic [CW-1:0]     cap_clamp;

	cell_probe_t       probe;
	cell_cmd_t         cmd;
	slot_t             slots [DEPTH];
	cell_flags_t       flags [DEPTH];
	logic [DEPTH-1:0]  match_v, ins_v, rd_v;
	logic [DEPTH-1:0]  ins_first, ins_gt, rem_first, rem_ge;
	logic [AW-1:0]     found_idx;
	logic [NOTE_W-1:0] rd_note;
	logic              rd_hit;

	act_t              act;
	status_t           status_d;
	logic [NOTE_W-1:0] nout_d;
	logic              nvalid_d;
	logic [AW-1:0]     fslot_d;
	logic [CW-1:0]     cnt_d;
	logic              full;
	logic              any_match;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
	assign op_in     = op_t'(s_tuser);

	// step target: wrap to the oldest note when at the front or stale
	always_comb begin
		if (step_q == '0 || CW'(step_q) > cnt_q) begin
			step_new = AW'(cnt_q - 1'b1);
		end else begin
			step_new = step_q - 1'b1;
		end
	end

	assign rd_addr = (op_in == OP_STEP) ? RW'(step_new) : RW'(s_tdata[11:7]);

	always_comb begin
		if (capacity_q == '0) begin
			cap_clamp = CW'(1);
		end else if (int'(capacity_q) > DEPTH) begin
			cap_clamp = CW'(DEPTH);
		end else begin
			cap_clamp = CW'(capacity_q);
		end
	end

	assign probe = '{capture: accept, ordered: ordered_q, key: s_tdata[NOTE_W-1:0]};
	assign cmd   = '{act: exec_fire ? act : ACT_HOLD, key: key_s1};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = slots[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = slots[i+1];
		end

		nsa_cell #(.IDX(i), .RW(RW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe    (probe),
			.rd_addr  (rd_addr),
			.cmd      (cmd),
			.ins_here (ins_first[i]),
			.shift_r  (ins_gt[i]),
			.shift_l  (rem_ge[i]),
			.left     (left_w),
			.right    (right_w),
			.slot     (slots[i]),
			.flags    (flags[i])
		);

		assign match_v[i] = flags[i].match;
		assign ins_v[i]   = flags[i].ins;
		assign rd_v[i]    = flags[i].rd;
	end

	// isolate the first hit, then mask the cells past it (insert) or at and past it (remove)
	assign ins_first = ins_v & (~ins_v + DEPTH'(1));
	assign ins_gt    = ~(ins_first - DEPTH'(1)) & ~ins_first;
	assign rem_first = match_v & (~match_v + DEPTH'(1));
	assign rem_ge    = ~(rem_first - DEPTH'(1));

	always_comb begin
		found_idx = '0;
		rd_note   = '0;
		rd_hit    = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rem_first[i]) begin
				found_idx = found_idx | AW'(i);
			end
			if (rd_v[i]) begin
				rd_note = rd_note | slots[i].note;
				rd_hit  = 1'b1;
			end
		end
	end

	assign full      = (cnt_q >= cap_q);
	assign any_match = |match_v;

	always_comb begin
		act      = ACT_HOLD;
		status_d = STS_DONE;
		nout_d   = '0;
		nvalid_d = 1'b0;
		fslot_d  = '0;
		cnt_d    = cnt_q;
		case (op_s1)
			OP_ADD, OP_ADD_ABSENT: begin
				if (op_s1 == OP_ADD_ABSENT && any_match) begin
					status_d = STS_MISS;
				end else if (full) begin
					status_d = STS_FULL;
				end else begin
					act   = ACT_INS;
					cnt_d = cnt_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (any_match) begin
					act   = ACT_REM;
					cnt_d = cnt_q - 1'b1;
				end else begin
					status_d = STS_MISS;
				end
			end
			OP_CONTAINS: begin
				if (any_match) begin
					fslot_d = found_idx;
				end else begin
					status_d = STS_MISS;
				end
			end
			OP_STEP: begin
				if (cnt_q == '0) begin
					status_d = STS_EMPTY;
				end else begin
					nout_d   = rd_note;
					nvalid_d = rd_hit;
				end
			end
			OP_READ: begin
				nout_d   = rd_note;
				nvalid_d = rd_hit;
			end
			OP_CLEAR: begin
				act   = ACT_CLR;
				cnt_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (exec_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			key_s1      <= s_tdata[NOTE_W-1:0];
			step_new_s1 <= step_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q  <= 1'b0;
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ORDERED) begin
				ordered_q <= cfg_data[0];
			end else begin
				capacity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
			cap_q  <= CAP_INIT;
		end else if (exec_fire) begin
			cnt_q <= cnt_d;
			if (op_s1 == OP_CLEAR) begin
				step_q <= '0;
				cap_q  <= cap_clamp;
			end else if (op_s1 == OP_STEP && cnt_q != '0) begin
				step_q <= step_new_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			status_q <= status_d;
			nout_q   <= nout_d;
			nvalid_q <= nvalid_d;
			fslot_q  <= SLOT_W'(fslot_d);
			count_q  <= CNT_W'(cnt_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, count_q, fslot_q, nout_q, status_q};
	assign m_tuser  = nvalid_q;

endmodule

>>> rtl/core/nsa_cell.sv
// One slot of the note stack: holds a note, compares it against the key,
// and shifts to or from its neighbors. Depends on nsa_pkg.
module nsa_cell #(
	parameter int IDX = 0,
	parameter int RW  = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nsa_pkg::cell_probe_t probe,
	input  logic [RW-1:0]       rd_addr,
	input  nsa_pkg::cell_cmd_t  cmd,
	input  logic                ins_here,
	input  logic                shift_r,
	input  logic                shift_l,
	input  nsa_pkg::slot_t      left,
	input  nsa_pkg::slot_t      right,
	output nsa_pkg::slot_t      slot,
	output nsa_pkg::cell_flags_t flags
);
	import nsa_pkg::*;

	logic              valid_q;
	logic [NOTE_W-1:0] note_q;
	slot_t             nxt;
	logic              match_s1;
	logic              ins_s1;
	logic              rd_s1;

	always_comb begin
		nxt = '{valid: valid_q, note: note_q};
		case (cmd.act)
			ACT_CLR: nxt.valid = 1'b0;
			ACT_INS: begin
				if (ins_here) begin
					nxt = '{valid: 1'b1, note: cmd.key};
				end else if (shift_r) begin
					nxt = left;
				end
			end
			ACT_REM: begin
				if (shift_l) begin
					nxt = right;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		note_q <= nxt.note;
	end

	// an empty slot is always a legal insert point, ordered or not
	always_ff @(posedge clk) begin
		if (probe.capture) begin
			match_s1 <= valid_q && (note_q == probe.key);
			ins_s1   <= !probe.ordered || !valid_q || (note_q >= probe.key);
			rd_s1    <= valid_q && (rd_addr == RW'(IDX));
		end
	end

	assign slot  = '{valid: valid_q, note: note_q};
	assign flags = '{match: match_s1, ins: ins_s1, rd: rd_s1};

endmodule

>>> rtl/core/nsa_check.sv
// Port-level checks for the note stack top level, attached by bind.
// Depends on nsa_pkg for the status codes.
module nsa_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);
	import nsa_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one word in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	a_note_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[1:0] == STS_DONE)
		else $error("valid note with non-done status");

	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == STS_EMPTY |-> m_tdata[19:14] == '0 && !m_tuser[0])
		else $error("empty status with notes held or a note returned");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13:9] != '0 |-> m_tdata[1:0] == STS_DONE)
		else $error("found slot given with non-done status");

endmodule

bind note_stack_with_arpeggio_step nsa_check u_nsa_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
